/* sv/pia_pkg.sv */
package pia_pkg;

    // Bus item kinds
    typedef enum logic [2:0] {
        CMD_BUS_READ  = 3'd0,
        CMD_BUS_WRITE = 3'd1,
        CMD_PINS_A    = 3'd2,
        CMD_PINS_B    = 3'd3,
        CMD_CA1       = 3'd4,
        CMD_CB1       = 3'd5,
        CMD_CA2       = 3'd6,
        CMD_CB2       = 3'd7
    } t_cmd;

    // Register selects
    typedef enum logic [1:0] {
        RS_PORT_A = 2'd0,
        RS_CTRL_A = 2'd1,
        RS_PORT_B = 2'd2,
        RS_CTRL_B = 2'd3
    } t_reg_select;

    // Control register bits
    localparam int unsigned CR_C1_EN   = 0;
    localparam int unsigned CR_C1_EDGE = 1;
    localparam int unsigned CR_DATASEL = 2;
    localparam int unsigned CR_C2_B3   = 3;
    localparam int unsigned CR_C2_B4   = 4;
    localparam int unsigned CR_C2_OUT  = 5;
    localparam int unsigned CR_C2_FLAG = 6;
    localparam int unsigned CR_C1_FLAG = 7;

    localparam logic [7:0] CR_WRITABLE = 8'h3F;
    localparam logic [7:0] CR_FLAGS    = 8'hC0;

    // Control line positions in the line level vector
    localparam int unsigned LN_CA1 = 0;
    localparam int unsigned LN_CA2 = 1;
    localparam int unsigned LN_CB1 = 2;
    localparam int unsigned LN_CB2 = 3;

    typedef struct packed {
        t_cmd        cmd;
        t_reg_select reg_select;
        logic [7:0]  data;
        logic        level;
    } t_pia_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] port_a_pins;
        logic [7:0] port_b_pins;
        logic       ca2_level;
        logic       cb2_level;
        logic       irq_a;
        logic       irq_b;
        logic       ca2_strobe;
        logic       cb2_strobe;
    } t_pia_out;

endpackage

/* sv/pia_in_if.sv */
interface pia_in_if;
    import pia_pkg::*;

    logic    valid;
    logic    ready;
    t_pia_in payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/pia_out_if.sv */
interface pia_out_if;
    import pia_pkg::*;

    logic     valid;
    logic     ready;
    t_pia_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/parallel_interface_adapter_unit.sv */
// An accepted transaction's result is registered into the output register.
// Throughput: one transaction per cycle while the output register is not stalled; all register updates
// are shallow logic that finishes in the accept cycle, so the next transaction sees the new state.
// Input is taken whenever the output register is empty or being drained.
// Reset (synchronous, active low) clears the port, control and line level registers and
// empties the output register; the held result payload is not cleared.
module parallel_interface_adapter_unit (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pia_in_if.sink   i_in,
    pia_out_if.source o_out
);
    import pia_pkg::*;

    logic [7:0] r_dir_a, r_out_a, r_in_a, r_ctrl_a;
    logic [7:0] r_dir_b, r_out_b, r_in_b, r_ctrl_b;
    logic [3:0] r_lines;
    logic       r_out_valid;
    t_pia_out   r_out;

    logic [7:0] n_dir_a, n_out_a, n_in_a, n_ctrl_a;
    logic [7:0] n_dir_b, n_out_b, n_in_b, n_ctrl_b;
    logic [3:0] n_lines;
    t_pia_out   n_out;
    logic       accept;

    // Interrupt request from one control register
    function automatic logic irq_of(input logic [7:0] c);
        return (c[CR_C1_FLAG] & c[CR_C1_EN])
             | (~c[CR_C2_OUT] & c[CR_C2_FLAG] & c[CR_C2_B3]);
    endfunction

    // Active edge detect, rising or falling by select
    function automatic logic edge_hit(input logic old_lv, input logic new_lv,
                                      input logic rising);
        return rising ? (~old_lv & new_lv) : (old_lv & ~new_lv);
    endfunction

    assign accept     = i_in.valid & i_in.ready;
    assign i_in.ready = ~r_out_valid | o_out.ready;

    // Compute next register state and the result of the transaction
    always_comb begin
        t_pia_in    it;
        logic [7:0] rd;
        logic       sa, sb;
        logic       act;
        it       = i_in.payload;
        rd       = '0;
        sa       = 1'b0;
        sb       = 1'b0;
        act      = 1'b0;
        n_dir_a  = r_dir_a;
        n_out_a  = r_out_a;
        n_in_a   = r_in_a;
        n_ctrl_a = r_ctrl_a;
        n_dir_b  = r_dir_b;
        n_out_b  = r_out_b;
        n_in_b   = r_in_b;
        n_ctrl_b = r_ctrl_b;
        n_lines  = r_lines;

        unique case (it.cmd)
            CMD_BUS_READ: begin
                unique case (it.reg_select)
                    RS_PORT_A: begin
                        if (r_ctrl_a[CR_DATASEL]) begin
                            rd = (r_out_a & r_dir_a) | (r_in_a & ~r_dir_a);
                            n_ctrl_a = r_ctrl_a & ~CR_FLAGS;
                            // handshake drives CA2 low, pulse mode strobes it
                            if (r_ctrl_a[CR_C2_OUT] && !r_ctrl_a[CR_C2_B4]) begin
                                n_lines[LN_CA2] = r_ctrl_a[CR_C2_B3];
                                sa = r_ctrl_a[CR_C2_B3];
                            end
                        end else begin
                            rd = r_dir_a;
                        end
                    end
                    RS_CTRL_A: rd = r_ctrl_a;
                    RS_PORT_B: begin
                        if (r_ctrl_b[CR_DATASEL]) begin
                            rd = (r_out_b & r_dir_b) | (r_in_b & ~r_dir_b);
                            n_ctrl_b = r_ctrl_b & ~CR_FLAGS;
                        end else begin
                            rd = r_dir_b;
                        end
                    end
                    default: rd = r_ctrl_b;
                endcase
            end
            CMD_BUS_WRITE: begin
                unique case (it.reg_select)
                    RS_PORT_A: begin
                        if (r_ctrl_a[CR_DATASEL]) n_out_a = it.data;
                        else n_dir_a = it.data;
                    end
                    RS_CTRL_A: begin
                        n_ctrl_a = (it.data & CR_WRITABLE) | (r_ctrl_a & CR_FLAGS);
                        if (n_ctrl_a[CR_C2_OUT]) begin
                            if (n_ctrl_a[CR_C2_B4]) n_lines[LN_CA2] = n_ctrl_a[CR_C2_B3];
                            else if (!r_ctrl_a[CR_C2_OUT]) n_lines[LN_CA2] = 1'b1;
                        end
                    end
                    RS_PORT_B: begin
                        if (r_ctrl_b[CR_DATASEL]) begin
                            n_out_b = it.data;
                            // handshake drives CB2 low, pulse mode strobes it
                            if (r_ctrl_b[CR_C2_OUT] && !r_ctrl_b[CR_C2_B4]) begin
                                n_lines[LN_CB2] = r_ctrl_b[CR_C2_B3];
                                sb = r_ctrl_b[CR_C2_B3];
                            end
                        end else begin
                            n_dir_b = it.data;
                        end
                    end
                    default: begin
                        n_ctrl_b = (it.data & CR_WRITABLE) | (r_ctrl_b & CR_FLAGS);
                        if (n_ctrl_b[CR_C2_OUT]) begin
                            if (n_ctrl_b[CR_C2_B4]) n_lines[LN_CB2] = n_ctrl_b[CR_C2_B3];
                            else if (!r_ctrl_b[CR_C2_OUT]) n_lines[LN_CB2] = 1'b1;
                        end
                    end
                endcase
            end
            CMD_PINS_A: n_in_a = it.data;
            CMD_PINS_B: n_in_b = it.data;
            CMD_CA1: begin
                act = edge_hit(r_lines[LN_CA1], it.level, r_ctrl_a[CR_C1_EDGE]);
                n_lines[LN_CA1] = it.level;
                if (act) begin
                    n_ctrl_a[CR_C1_FLAG] = 1'b1;
                    if (r_ctrl_a[CR_C2_OUT] && !r_ctrl_a[CR_C2_B4] && !r_ctrl_a[CR_C2_B3])
                        n_lines[LN_CA2] = 1'b1;
                end
            end
            CMD_CB1: begin
                act = edge_hit(r_lines[LN_CB1], it.level, r_ctrl_b[CR_C1_EDGE]);
                n_lines[LN_CB1] = it.level;
                if (act) begin
                    n_ctrl_b[CR_C1_FLAG] = 1'b1;
                    if (r_ctrl_b[CR_C2_OUT] && !r_ctrl_b[CR_C2_B4] && !r_ctrl_b[CR_C2_B3])
                        n_lines[LN_CB2] = 1'b1;
                end
            end
            CMD_CA2: begin
                // drop the level when CA2 is an output
                if (!r_ctrl_a[CR_C2_OUT]) begin
                    act = edge_hit(r_lines[LN_CA2], it.level, r_ctrl_a[CR_C2_B4]);
                    n_lines[LN_CA2] = it.level;
                    if (act) n_ctrl_a[CR_C2_FLAG] = 1'b1;
                end
            end
            default: begin
                if (!r_ctrl_b[CR_C2_OUT]) begin
                    act = edge_hit(r_lines[LN_CB2], it.level, r_ctrl_b[CR_C2_B4]);
                    n_lines[LN_CB2] = it.level;
                    if (act) n_ctrl_b[CR_C2_FLAG] = 1'b1;
                end
            end
        endcase

        n_out.read_data   = rd;
        n_out.port_a_pins = n_out_a & n_dir_a;
        n_out.port_b_pins = n_out_b & n_dir_b;
        n_out.ca2_level   = n_lines[LN_CA2];
        n_out.cb2_level   = n_lines[LN_CB2];
        n_out.irq_a       = irq_of(n_ctrl_a);
        n_out.irq_b       = irq_of(n_ctrl_b);
        n_out.ca2_strobe  = sa;
        n_out.cb2_strobe  = sb;
    end

    // Advance state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_a  <= '0;
            r_out_a  <= '0;
            r_in_a   <= '0;
            r_ctrl_a <= '0;
            r_dir_b  <= '0;
            r_out_b  <= '0;
            r_in_b   <= '0;
            r_ctrl_b <= '0;
            r_lines  <= '0;
        end else if (accept) begin
            r_dir_a  <= n_dir_a;
            r_out_a  <= n_out_a;
            r_in_a   <= n_in_a;
            r_ctrl_a <= n_ctrl_a;
            r_dir_b  <= n_dir_b;
            r_out_b  <= n_out_b;
            r_in_b   <= n_in_b;
            r_ctrl_b <= n_ctrl_b;
            r_lines  <= n_lines;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

/* sv/pia_checker.sv */
module pia_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input pia_pkg::t_pia_out i_out_payload
);
    import pia_pkg::*;

    // Every accepted transaction shows a result in the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted transaction gave no result");

    // Output register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A strobe always leaves its line high
    a_strobe_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((!i_out_payload.ca2_strobe || i_out_payload.ca2_level)
                      && (!i_out_payload.cb2_strobe || i_out_payload.cb2_level)))
        else $error("strobe with line low");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_payload)))
        else $error("stalled result changed");

endmodule

bind parallel_interface_adapter_unit pia_checker u_pia_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

/* verif/parallel_interface_adapter_unit_tb.sv */
module parallel_interface_adapter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pia_pkg::*;

    localparam int EVENT_TARGET = 900;
    localparam int MAX_WAIT     = 12;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pia_in_if  in_if();
    pia_out_if out_if();

    parallel_interface_adapter_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Shadow copy of the adapter registers, index 0 is side A and 1 is side B
    logic [7:0] dir_reg  [2] = '{8'h00, 8'h00};
    logic [7:0] out_reg  [2] = '{8'h00, 8'h00};
    logic [7:0] in_reg   [2] = '{8'h00, 8'h00};
    logic [7:0] ctrl_reg [2] = '{8'h00, 8'h00};
    logic [3:0] line_lvl     = 4'h0;

    t_pia_in  pending_events[$];
    t_pia_out expected_responses[$];

    int  total_events  = 0;
    int  events_sent   = 0;
    int  error_count   = 0;
    int  quiet_cycles  = 0;
    int  send_gap      = 0;
    int  recv_stall    = 0;
    bit  send_burst    = 1'b0;
    bit  recv_burst    = 1'b0;
    bit  event_taken   = 1'b0;

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic edge_seen(input logic was, input logic now, input logic rising);
        return rising ? (!was && now) : (was && !now);
    endfunction

    function automatic logic irq_of_ctrl(input logic [7:0] cr);
        return (cr[CR_C1_FLAG] && cr[CR_C1_EN]) ||
               (!cr[CR_C2_OUT] && cr[CR_C2_FLAG] && cr[CR_C2_B3]);
    endfunction

    // Handshake (low) or pulse (strobe, ends high) on C2 after a port access
    task automatic c2_handshake(input logic [7:0] cr, input int unsigned c2,
                                output logic strobe);
        strobe = 1'b0;
        if (cr[CR_C2_OUT] && !cr[CR_C2_B4]) begin
            if (cr[CR_C2_B3]) begin
                line_lvl[c2] = 1'b1;
                strobe       = 1'b1;
            end else begin
                line_lvl[c2] = 1'b0;
            end
        end
    endtask

    // Advance the shadow registers by one transaction and build its response
    task automatic adapter_response(input t_pia_in ev, output t_pia_out resp);
        int unsigned side;
        int unsigned c1;
        int unsigned c2;
        logic        on_ctrl;
        logic        was_out;
        logic        strobe;
        logic [7:0]  cr;
        resp   = '0;
        strobe = 1'b0;
        if (ev.cmd == CMD_BUS_READ || ev.cmd == CMD_BUS_WRITE)
            side = (ev.reg_select == RS_PORT_B || ev.reg_select == RS_CTRL_B) ? 1 : 0;
        else
            side = (ev.cmd == CMD_PINS_B || ev.cmd == CMD_CB1 || ev.cmd == CMD_CB2) ? 1 : 0;
        on_ctrl = (ev.reg_select == RS_CTRL_A || ev.reg_select == RS_CTRL_B);
        c1 = side ? LN_CB1 : LN_CA1;
        c2 = side ? LN_CB2 : LN_CA2;
        cr = ctrl_reg[side];
        case (ev.cmd)
            CMD_BUS_READ: begin
                if (on_ctrl) begin
                    resp.read_data = cr;
                end else if (cr[CR_DATASEL]) begin
                    resp.read_data = (out_reg[side] & dir_reg[side]) |
                                     (in_reg[side] & ~dir_reg[side]);
                    cr = cr & ~CR_FLAGS;
                    // only port A reads drive the C2 handshake
                    if (side == 0)
                        c2_handshake(cr, c2, strobe);
                end else begin
                    resp.read_data = dir_reg[side];
                end
            end
            CMD_BUS_WRITE: begin
                if (on_ctrl) begin
                    was_out = cr[CR_C2_OUT];
                    cr = (ev.data & CR_WRITABLE) | (cr & CR_FLAGS);
                    if (cr[CR_C2_OUT]) begin
                        if (cr[CR_C2_B4])
                            line_lvl[c2] = cr[CR_C2_B3];
                        else if (!was_out)
                            line_lvl[c2] = 1'b1;
                    end
                end else if (cr[CR_DATASEL]) begin
                    out_reg[side] = ev.data;
                    // only port B writes drive the C2 handshake
                    if (side == 1)
                        c2_handshake(cr, c2, strobe);
                end else begin
                    dir_reg[side] = ev.data;
                end
            end
            CMD_PINS_A, CMD_PINS_B: begin
                in_reg[side] = ev.data;
            end
            CMD_CA1, CMD_CB1: begin
                if (edge_seen(line_lvl[c1], ev.level, cr[CR_C1_EDGE])) begin
                    cr[CR_C1_FLAG] = 1'b1;
                    if (cr[CR_C2_OUT] && !cr[CR_C2_B4] && !cr[CR_C2_B3])
                        line_lvl[c2] = 1'b1;
                end
                line_lvl[c1] = ev.level;
            end
            CMD_CA2, CMD_CB2: begin
                // drop the event while C2 is an output
                if (!cr[CR_C2_OUT]) begin
                    if (edge_seen(line_lvl[c2], ev.level, cr[CR_C2_B4]))
                        cr[CR_C2_FLAG] = 1'b1;
                    line_lvl[c2] = ev.level;
                end
            end
        endcase
        ctrl_reg[side] = cr;
        if (side == 1)
            resp.cb2_strobe = strobe;
        else
            resp.ca2_strobe = strobe;
        resp.port_a_pins = out_reg[0] & dir_reg[0];
        resp.port_b_pins = out_reg[1] & dir_reg[1];
        resp.ca2_level   = line_lvl[LN_CA2];
        resp.cb2_level   = line_lvl[LN_CB2];
        resp.irq_a       = irq_of_ctrl(ctrl_reg[0]);
        resp.irq_b       = irq_of_ctrl(ctrl_reg[1]);
    endtask

    task automatic queue_event(input t_cmd cmd, input t_reg_select rs,
                               input logic [7:0] data, input logic lv);
        t_pia_in ev;
        ev.cmd        = cmd;
        ev.reg_select = rs;
        ev.data       = data;
        ev.level      = lv;
        pending_events.push_back(ev);
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            error_count++;
        end
    endtask

    // Drive input transactions at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || event_taken) begin
            if (send_gap > 0) begin
                in_if.valid <= 1'b0;
                send_gap--;
            end else if (pending_events.size() > 0) begin
                in_if.payload <= pending_events.pop_front();
                in_if.valid   <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                send_gap = draw_gap(send_burst);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
        event_taken = 1'b0;
    end

    // Predict each accepted input transaction
    always @(posedge i_clk) begin : predict_accepted
        t_pia_out resp;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            adapter_response(in_if.payload, resp);
            expected_responses.push_back(resp);
            events_sent++;
            event_taken = 1'b1;
        end
    end

    // Stall the result side at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (recv_stall > 0) begin
            out_if.ready <= 1'b0;
            recv_stall--;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_pia_out want;
        t_pia_out got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.payload;
            if (expected_responses.size() == 0) begin
                $display("%0t ns: result with no transaction pending, expected none, actual %p",
                         $time, got);
                error_count++;
            end else begin
                want = expected_responses.pop_front();
                check_field("read_data",   want.read_data,   got.read_data);
                check_field("port_a_pins", want.port_a_pins, got.port_a_pins);
                check_field("port_b_pins", want.port_b_pins, got.port_b_pins);
                check_field("ca2_level",   8'(want.ca2_level),  8'(got.ca2_level));
                check_field("cb2_level",   8'(want.cb2_level),  8'(got.cb2_level));
                check_field("irq_a",       8'(want.irq_a),      8'(got.irq_a));
                check_field("irq_b",       8'(want.irq_b),      8'(got.irq_b));
                check_field("ca2_strobe",  8'(want.ca2_strobe), 8'(got.ca2_strobe));
                check_field("cb2_strobe",  8'(want.cb2_strobe), 8'(got.cb2_strobe));
            end
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            recv_stall = draw_gap(recv_burst);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("parallel_interface_adapter_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        bit         side_b;
        logic [7:0] ctrl_val;
        int         pick;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;

        // Directed: flag bits are read-only, set/reset mode drives CA2 high
        queue_event(CMD_BUS_WRITE, RS_CTRL_A, 8'hFF, 1'b1);
        // CA2 event is ignored while CA2 is an output
        queue_event(CMD_CA2,       RS_PORT_A, 8'hFF, 1'b0);
        // DDR access: all of port A driven
        queue_event(CMD_BUS_WRITE, RS_CTRL_A, 8'h00, 1'b0);
        queue_event(CMD_BUS_WRITE, RS_PORT_A, 8'hFF, 1'b0);
        queue_event(CMD_BUS_READ,  RS_PORT_A, 8'h00, 1'b1);
        // pulse mode on CA2, falling CA1 with interrupt enabled
        queue_event(CMD_BUS_WRITE, RS_CTRL_A, 8'h2D, 1'b0);
        queue_event(CMD_BUS_WRITE, RS_PORT_A, 8'hA5, 1'b0);
        queue_event(CMD_PINS_A,    RS_CTRL_B, 8'h3C, 1'b1);
        queue_event(CMD_CA1,       RS_PORT_A, 8'hFF, 1'b1);
        queue_event(CMD_CA1,       RS_PORT_A, 8'h00, 1'b0);
        queue_event(CMD_BUS_READ,  RS_PORT_A, 8'hFF, 1'b0);
        // handshake mode: port A read drops CA2, active CA1 raises it
        queue_event(CMD_BUS_WRITE, RS_CTRL_A, 8'h25, 1'b0);
        queue_event(CMD_BUS_READ,  RS_PORT_A, 8'h00, 1'b0);
        queue_event(CMD_CA1,       RS_PORT_A, 8'h00, 1'b1);
        queue_event(CMD_CA1,       RS_PORT_A, 8'h00, 1'b0);
        // side B: C2 input, rising edges, interrupt on CB2
        queue_event(CMD_BUS_WRITE, RS_PORT_B, 8'h0F, 1'b0);
        queue_event(CMD_BUS_WRITE, RS_CTRL_B, 8'h1E, 1'b0);
        queue_event(CMD_CB2,       RS_CTRL_A, 8'h00, 1'b1);
        queue_event(CMD_CB1,       RS_CTRL_A, 8'h00, 1'b1);
        queue_event(CMD_PINS_B,    RS_PORT_A, 8'hF0, 1'b0);
        queue_event(CMD_BUS_READ,  RS_PORT_B, 8'h00, 1'b0);
        // pulse then handshake on port B writes, then set/reset low
        queue_event(CMD_BUS_WRITE, RS_CTRL_B, 8'h2C, 1'b0);
        queue_event(CMD_BUS_WRITE, RS_PORT_B, 8'h55, 1'b0);
        queue_event(CMD_BUS_WRITE, RS_CTRL_B, 8'h24, 1'b0);
        queue_event(CMD_BUS_WRITE, RS_PORT_B, 8'hAA, 1'b0);
        queue_event(CMD_BUS_WRITE, RS_CTRL_B, 8'h30, 1'b0);
        // C2 flag is kept but masked once C2 turns output
        queue_event(CMD_BUS_WRITE, RS_CTRL_A, 8'h08, 1'b0);
        queue_event(CMD_CA2,       RS_PORT_A, 8'h00, 1'b1);
        queue_event(CMD_CA2,       RS_PORT_A, 8'h00, 1'b0);
        queue_event(CMD_BUS_WRITE, RS_CTRL_A, 8'h28, 1'b0);
        queue_event(CMD_BUS_READ,  RS_CTRL_A, 8'h00, 1'b0);

        // Random: mostly a control setup followed by traffic on the same side
        while (pending_events.size() < EVENT_TARGET) begin
            if ($urandom_range(0, 9) < 7) begin
                side_b   = 1'($urandom_range(0, 1));
                ctrl_val = 8'($urandom_range(0, 255));
                queue_event(CMD_BUS_WRITE, side_b ? RS_CTRL_B : RS_CTRL_A, ctrl_val,
                            1'($urandom_range(0, 1)));
                repeat ($urandom_range(3, 10)) begin
                    pick = $urandom_range(0, 7);
                    case (pick)
                        0, 1: queue_event(CMD_BUS_READ, side_b ? RS_PORT_B : RS_PORT_A,
                                          8'($urandom_range(0, 255)),
                                          1'($urandom_range(0, 1)));
                        2: queue_event(CMD_BUS_WRITE, side_b ? RS_PORT_B : RS_PORT_A,
                                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                        3: queue_event(CMD_BUS_READ, side_b ? RS_CTRL_B : RS_CTRL_A,
                                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                        4: queue_event(side_b ? CMD_PINS_B : CMD_PINS_A,
                                       t_reg_select'($urandom_range(0, 3)),
                                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                        5: queue_event(side_b ? CMD_CB1 : CMD_CA1,
                                       t_reg_select'($urandom_range(0, 3)),
                                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                        6: queue_event(side_b ? CMD_CB2 : CMD_CA2,
                                       t_reg_select'($urandom_range(0, 3)),
                                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                        default: begin
                            // flip between direction and data register access
                            ctrl_val[CR_DATASEL] = ~ctrl_val[CR_DATASEL];
                            queue_event(CMD_BUS_WRITE, side_b ? RS_CTRL_B : RS_CTRL_A,
                                        ctrl_val, 1'($urandom_range(0, 1)));
                        end
                    endcase
                end
            end else begin
                queue_event(t_cmd'($urandom_range(0, 7)), t_reg_select'($urandom_range(0, 3)),
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
        total_events = pending_events.size();

        // Hold reset, then release
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all transactions to drain
        while (events_sent < total_events || expected_responses.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_responses.size() == 0) begin
            $display("parallel_interface_adapter_unit verification clean");
        end else begin
            $display("parallel_interface_adapter_unit verification failed");
        end
        $finish;
    end

endmodule
